// ===== design/chte_pkg.sv =====
// shared types and constants for the chained hash table engine
// no dependencies
`default_nettype none
package chte_pkg;
  localparam int BUCKETS = 64;
  localparam int ENTRIES = 256;
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int LINK_W  = IDX_W + 1;
  localparam int CNT_W   = IDX_W + 1;
  localparam logic [LINK_W-1:0] NO_ENTRY = LINK_W'(ENTRIES);

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef enum logic [1:0] {OP_INSERT, OP_SEARCH, OP_REMOVE, OP_NONE} op_t;

  typedef enum logic [1:0] {S_IDLE, S_HEAD, S_CMP} state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] hash;
  } cmd_t;
endpackage
`default_nettype wire

// ===== design/chained_hash_table_engine_core.sv =====
// top level of the chained hash table engine: front queue plus back end
// depends on chte_pkg, chte_front, chte_back
// Commands (insert, search, remove) enter while busy is low and wait in a
// two-word queue. Each gives exactly one result, shown for one cycle with
// done high, in command order, and it cannot be held off. An insert, an
// unused kind or a search or remove of an empty bucket gives its result
// from the S_HEAD state. A search or remove that visits chain entries
// walks them in S_CMP, one read per cycle of the entry memory. The back
// end takes a new word only in S_IDLE, once the last one is through.
// No clearing pass after reset.
`default_nettype none
module chained_hash_table_engine_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] key,
  input  wire logic [31:0] value,
  input  wire logic [31:0] hash,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      found_value,
  output logic [31:0]      found_key
);
  import chte_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_take;

  chte_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .key(key), .value(value), .hash(hash),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
  );

  chte_back u_back (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid),
    .cmd_take(cmd_take), .done(done), .status(status),
    .found_value(found_value), .found_key(found_key)
  );
endmodule
`default_nettype wire

// ===== design/chte_front.sv =====
// front end: takes command words, decodes the operation and queues them
// depends on chte_pkg
`default_nettype none
module chte_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         kind,
  input  wire logic [31:0]        key,
  input  wire logic [31:0]        value,
  input  wire logic [31:0]        hash,
  output chte_pkg::cmd_t          cmd,
  output logic                    cmd_valid,
  input  wire logic               cmd_take
);
  import chte_pkg::*;

  cmd_t       q [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  op_t        op_dec;
  logic       push;

  always_comb begin
    case (kind)
      KIND_INSERT: op_dec = OP_INSERT;
      KIND_SEARCH: op_dec = OP_SEARCH;
      KIND_REMOVE: op_dec = OP_REMOVE;
      default:     op_dec = OP_NONE;
    endcase
  end

  assign busy      = (count == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{op: op_dec, key: key, value: value, hash: hash};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_take) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(cmd_take);
    end
  end
endmodule
`default_nettype wire

// ===== design/chte_back.sv =====
// back end: bucket heads, entry pool, free list and the chain walker
// depends on chte_pkg
`default_nettype none
module chte_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  chte_pkg::cmd_t          cmd,
  input  wire logic               cmd_valid,
  output logic                    cmd_take,
  output logic                    done,
  output logic [1:0]              status,
  output logic [31:0]             found_value,
  output logic [31:0]             found_key
);
  import chte_pkg::*;

  state_t state, state_next;

  // memories
  logic [LINK_W-1:0] head_mem  [BUCKETS];
  logic [95:0]       ent_mem   [ENTRIES];
  logic [LINK_W-1:0] link_mem  [ENTRIES];
  logic [IDX_W-1:0]  stack_mem [ENTRIES];
  logic [BUCKETS-1:0] head_ok;

  op_t               op;
  logic [31:0]       op_key, op_value, op_hash;
  logic [BKT_W-1:0]  bkt;
  logic [LINK_W-1:0] head_rd;
  logic              head_ok_rd;
  logic [LINK_W-1:0] head_cur;
  logic [95:0]       ent_rd;
  logic [LINK_W-1:0] link_rd;
  logic [IDX_W-1:0]  pop_rd;
  logic [LINK_W-1:0] cur, prev;
  logic [CNT_W-1:0]  rcnt, fcnt;
  logic              full, match;
  logic [IDX_W-1:0]  alloc, ent_raddr;
  logic [CNT_W-1:0]  rcnt_dec;

  assign bkt      = op_hash[BKT_W-1:0];
  assign head_cur = head_ok_rd ? head_rd : NO_ENTRY;
  assign full     = (rcnt == '0) && (fcnt == CNT_W'(ENTRIES));
  assign alloc    = (rcnt != '0) ? pop_rd : fcnt[IDX_W-1:0];
  assign match    = (ent_rd[31:0] == op_hash) && (ent_rd[95:64] == op_key);
  assign rcnt_dec = rcnt - 1'b1;
  assign ent_raddr = (state == S_HEAD) ? head_cur[IDX_W-1:0] : link_rd[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take   = 1'b1;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        if ((op == OP_SEARCH || op == OP_REMOVE) && head_cur != NO_ENTRY)
          state_next = S_CMP;
        else
          state_next = S_IDLE;
      end
      S_CMP: begin
        if (match || link_rd == NO_ENTRY) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // registered reads
  always_ff @(posedge clk) begin
    head_rd <= head_mem[cmd.hash[BKT_W-1:0]];
    ent_rd  <= ent_mem[ent_raddr];
    link_rd <= link_mem[ent_raddr];
    pop_rd  <= stack_mem[rcnt_dec[IDX_W-1:0]];
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (state == S_HEAD && op == OP_INSERT && !full) begin
      ent_mem[alloc]  <= {op_key, op_value, op_hash};
      link_mem[alloc] <= head_cur;
      head_mem[bkt]   <= LINK_W'(alloc);
    end else if (state == S_CMP && match && op == OP_REMOVE) begin
      if (prev == NO_ENTRY) head_mem[bkt] <= link_rd;
      else                  link_mem[prev[IDX_W-1:0]] <= link_rd;
      stack_mem[rcnt[IDX_W-1:0]] <= cur[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      op       <= cmd.op;
      op_key   <= cmd.key;
      op_value <= cmd.value;
      op_hash  <= cmd.hash;
    end
    if (state == S_IDLE) head_ok_rd <= head_ok[cmd.hash[BKT_W-1:0]];
    if (state == S_HEAD) begin
      cur  <= head_cur;
      prev <= NO_ENTRY;
    end else if (state == S_CMP && !match) begin
      prev <= cur;
      cur  <= link_rd;
    end
  end

  // control state: bucket valid bits, free list counts, result strobe and fields
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ok     <= '0;
      rcnt        <= '0;
      fcnt        <= '0;
      done        <= 1'b0;
      status      <= ST_DONE;
      found_value <= '0;
      found_key   <= '0;
    end else begin
      done        <= 1'b0;
      found_value <= '0;
      found_key   <= '0;
      case (state)
        S_HEAD: begin
          if (op == OP_INSERT) begin
            done <= 1'b1;
            if (full) begin
              status <= ST_FULL;
            end else begin
              status       <= ST_DONE;
              head_ok[bkt] <= 1'b1;
              if (rcnt != '0) rcnt <= rcnt_dec;
              else            fcnt <= fcnt + 1'b1;
            end
          end else if (op == OP_NONE || head_cur == NO_ENTRY) begin
            done   <= 1'b1;
            status <= ST_NOTFOUND;
          end
        end
        S_CMP: begin
          if (match) begin
            done        <= 1'b1;
            status      <= ST_DONE;
            found_key   <= ent_rd[95:64];
            found_value <= ent_rd[63:32];
            if (op == OP_REMOVE) rcnt <= rcnt + 1'b1;
          end else if (link_rd == NO_ENTRY) begin
            done   <= 1'b1;
            status <= ST_NOTFOUND;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
